// ===== rtl/cpu8am_pkg.sv =====
package cpu8am_pkg;

  typedef enum logic [3:0] {
    MODE_IMP = 4'd0,
    MODE_IMM = 4'd1,
    MODE_ZP0 = 4'd2,
    MODE_ZPX = 4'd3,
    MODE_ZPY = 4'd4,
    MODE_REL = 4'd5,
    MODE_ABS = 4'd6,
    MODE_ABX = 4'd7,
    MODE_ABY = 4'd8,
    MODE_IND = 4'd9,
    MODE_IZX = 4'd10,
    MODE_IZY = 4'd11
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPER1  = 3'd1,
    PH_OPER2  = 3'd2,
    PH_PTR_LO = 3'd3,
    PH_PTR_HI = 3'd4
  } phase_t;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [15:0] PAGE_MASK   = 16'hFF00;
  localparam logic [15:0] OFFSET_MASK = 16'h00FF;

  typedef struct packed {
    phase_t      phase;
    mode_t       mode;
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] pointer;
    logic [7:0]  low_byte;
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  rel_offset;
    logic [15:0] next_pc;
    logic        page_cross;
  } ea_result_t;

endpackage

// ===== rtl/cpu8am_calc.sv =====
module cpu8am_calc (
  input  logic                   req_type,
  input  logic [3:0]             mode,
  input  logic [15:0]            pc,
  input  logic [7:0]             x_index,
  input  logic [7:0]             y_index,
  input  logic [7:0]             read_data,
  input  cpu8am_pkg::state_t     st,
  output cpu8am_pkg::state_t     st_nxt,
  output logic                   emit,
  output cpu8am_pkg::ea_result_t res
);

  logic [15:0] pc1;
  logic [15:0] pc2;
  logic [15:0] base;
  logic [15:0] idx_ea;
  logic [7:0]  idx_val;
  logic        idx_cross;
  logic [15:0] ptr_zp;
  logic [15:0] ptr_hi_addr;
  logic [15:0] rel_target;

  assign pc1  = st.pc + 16'd1;
  assign pc2  = st.pc + 16'd2;
  assign base = {read_data, st.low_byte};

  // IZY indexes by Y as does ABY; ABX is the only mode this mux indexes by X
  assign idx_val   = (st.mode == cpu8am_pkg::MODE_ABX) ? st.x : st.y;
  assign idx_ea    = base + {8'd0, idx_val};
  assign idx_cross = (idx_ea[15:8] != base[15:8]);

  assign ptr_zp      = {8'd0, read_data + st.x};
  // high pointer byte stays within the pointer's page
  assign ptr_hi_addr = (st.pointer & cpu8am_pkg::PAGE_MASK)
                     | ((st.pointer + 16'd1) & cpu8am_pkg::OFFSET_MASK);
  assign rel_target  = pc1 + {{8{read_data[7]}}, read_data};

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '0;
    if (req_type == cpu8am_pkg::REQ_START) begin
      st_nxt.mode     = cpu8am_pkg::mode_t'(mode);
      st_nxt.pc       = pc;
      st_nxt.x        = x_index;
      st_nxt.y        = y_index;
      st_nxt.pointer  = '0;
      st_nxt.low_byte = '0;
      st_nxt.phase    = cpu8am_pkg::PH_IDLE;
      emit            = 1'b1;
      if (mode == cpu8am_pkg::MODE_IMM) begin
        res.kind    = cpu8am_pkg::KIND_DONE;
        res.address = pc;
        res.next_pc = pc + 16'd1;
      end else if (mode >= cpu8am_pkg::MODE_ZP0 && mode <= cpu8am_pkg::MODE_IZY) begin
        res.kind     = cpu8am_pkg::KIND_READ;
        res.address  = pc;
        st_nxt.phase = cpu8am_pkg::PH_OPER1;
      end else begin
        res.kind    = cpu8am_pkg::KIND_DONE;
        res.next_pc = pc;
      end
    end else begin
      st_nxt.phase = cpu8am_pkg::PH_IDLE;
      unique case (st.phase)
        cpu8am_pkg::PH_OPER1: begin
          case (st.mode) inside
            cpu8am_pkg::MODE_ZP0: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = {8'd0, read_data};
              res.next_pc = pc1;
            end
            cpu8am_pkg::MODE_ZPX: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = {8'd0, read_data + st.x};
              res.next_pc = pc1;
            end
            cpu8am_pkg::MODE_ZPY: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = {8'd0, read_data + st.y};
              res.next_pc = pc1;
            end
            cpu8am_pkg::MODE_REL: begin
              emit           = 1'b1;
              res.kind       = cpu8am_pkg::KIND_DONE;
              res.address    = rel_target;
              res.rel_offset = read_data;
              res.next_pc    = pc1;
            end
            cpu8am_pkg::MODE_ABS, cpu8am_pkg::MODE_ABX,
            cpu8am_pkg::MODE_ABY, cpu8am_pkg::MODE_IND: begin
              emit            = 1'b1;
              st_nxt.low_byte = read_data;
              st_nxt.phase    = cpu8am_pkg::PH_OPER2;
              res.kind        = cpu8am_pkg::KIND_READ;
              res.address     = pc1;
            end
            cpu8am_pkg::MODE_IZX: begin
              emit           = 1'b1;
              st_nxt.pointer = ptr_zp;
              st_nxt.phase   = cpu8am_pkg::PH_PTR_LO;
              res.kind       = cpu8am_pkg::KIND_READ;
              res.address    = ptr_zp;
            end
            cpu8am_pkg::MODE_IZY: begin
              emit           = 1'b1;
              st_nxt.pointer = {8'd0, read_data};
              st_nxt.phase   = cpu8am_pkg::PH_PTR_LO;
              res.kind       = cpu8am_pkg::KIND_READ;
              res.address    = {8'd0, read_data};
            end
            default: ;
          endcase
        end
        cpu8am_pkg::PH_OPER2: begin
          case (st.mode) inside
            cpu8am_pkg::MODE_ABS: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = base;
              res.next_pc = pc2;
            end
            cpu8am_pkg::MODE_ABX, cpu8am_pkg::MODE_ABY: begin
              emit           = 1'b1;
              res.kind       = cpu8am_pkg::KIND_DONE;
              res.address    = idx_ea;
              res.next_pc    = pc2;
              res.page_cross = idx_cross;
            end
            cpu8am_pkg::MODE_IND: begin
              emit           = 1'b1;
              st_nxt.pointer = base;
              st_nxt.phase   = cpu8am_pkg::PH_PTR_LO;
              res.kind       = cpu8am_pkg::KIND_READ;
              res.address    = base;
            end
            default: ;
          endcase
        end
        cpu8am_pkg::PH_PTR_LO: begin
          if (st.mode == cpu8am_pkg::MODE_IND || st.mode == cpu8am_pkg::MODE_IZX ||
              st.mode == cpu8am_pkg::MODE_IZY) begin
            emit            = 1'b1;
            st_nxt.low_byte = read_data;
            st_nxt.phase    = cpu8am_pkg::PH_PTR_HI;
            res.kind        = cpu8am_pkg::KIND_READ;
            res.address     = ptr_hi_addr;
          end
        end
        cpu8am_pkg::PH_PTR_HI: begin
          case (st.mode)
            cpu8am_pkg::MODE_IND: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = base;
              res.next_pc = pc2;
            end
            cpu8am_pkg::MODE_IZX: begin
              emit        = 1'b1;
              res.kind    = cpu8am_pkg::KIND_DONE;
              res.address = base;
              res.next_pc = pc1;
            end
            cpu8am_pkg::MODE_IZY: begin
              emit           = 1'b1;
              res.kind       = cpu8am_pkg::KIND_DONE;
              res.address    = idx_ea;
              res.next_pc    = pc1;
              res.page_cross = idx_cross;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cpu8_address_mode_unit_top.sv =====
// Effective-address unit for the classic 8-bit CPU addressing modes. A start
// transfer (req_type 0) loads mode, PC, X and Y; each data transfer
// (req_type 1) returns the byte for the previous read request. Every transfer
// yields at most one result: a read request (kind 0) or a done result
// (kind 1). Data that arrives with no calculation running yields nothing.
// Results appear in the output register in the cycle after the input transfer,
// and a new input transfer is taken every cycle as long as that register is
// empty or being drained in the same cycle, so the unit sustains one transfer
// per clock.
module cpu8_address_mode_unit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [3:0]         in_mode,
  input  logic [15:0]        in_pc,
  input  logic [7:0]         in_x_index,
  input  logic [7:0]         in_y_index,
  input  logic [7:0]         in_read_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [15:0]        out_address,
  output logic signed [7:0]  out_rel_offset,
  output logic [15:0]        out_next_pc,
  output logic               out_page_cross
);

  cpu8am_pkg::state_t     st_r;
  cpu8am_pkg::state_t     st_nxt;
  cpu8am_pkg::ea_result_t res_r;
  cpu8am_pkg::ea_result_t res_nxt;
  logic                   out_valid_r;
  logic                   emit;
  logic                   in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  cpu8am_calc u_calc (
    .req_type  (in_req_type),
    .mode      (in_mode),
    .pc        (in_pc),
    .x_index   (in_x_index),
    .y_index   (in_y_index),
    .read_data (in_read_data),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: cpu8am_pkg::PH_IDLE, mode: cpu8am_pkg::MODE_IMP, default: '0};
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_address    = res_r.address;
  assign out_rel_offset = $signed(res_r.rel_offset);
  assign out_next_pc    = res_r.next_pc;
  assign out_page_cross = res_r.page_cross;

  a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == cpu8am_pkg::KIND_READ |->
      res_r.next_pc == 16'd0 && res_r.rel_offset == 8'd0 && !res_r.page_cross)
    else $error("read request carries done-only fields");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && emit && res_nxt.kind == cpu8am_pkg::KIND_DONE |=>
      st_r.phase == cpu8am_pkg::PH_IDLE)
    else $error("phase not idle after done result");

  a_imm_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_req_type == cpu8am_pkg::REQ_START &&
    in_mode == cpu8am_pkg::MODE_IMM |=>
      out_valid_r && res_r.kind == cpu8am_pkg::KIND_DONE &&
      res_r.address == $past(in_pc))
    else $error("immediate mode result wrong");

  a_ptr_hi_same_page: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && st_r.phase == cpu8am_pkg::PH_PTR_LO &&
    in_req_type == cpu8am_pkg::REQ_DATA && emit |->
      res_nxt.address[15:8] == st_r.pointer[15:8])
    else $error("pointer high fetch left the pointer page");

  a_idle_data_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_req_type == cpu8am_pkg::REQ_DATA && st_r.phase == cpu8am_pkg::PH_IDLE |->
      !emit)
    else $error("data with no calculation produced a result");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [3:0]  in_mode;
  logic [15:0] in_pc;
  logic [7:0]  in_x_index;
  logic [7:0]  in_y_index;
  logic [7:0]  in_read_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [15:0] out_address;
  logic signed [7:0] out_rel_offset;
  logic [15:0] out_next_pc;
  logic        out_page_cross;

  cpu8_address_mode_unit_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_mode       (in_mode),
    .in_pc         (in_pc),
    .in_x_index    (in_x_index),
    .in_y_index    (in_y_index),
    .in_read_data  (in_read_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_address   (out_address),
    .out_rel_offset(out_rel_offset),
    .out_next_pc   (out_next_pc),
    .out_page_cross(out_page_cross)
  );

  // predicted unit state
  cpu8am_pkg::phase_t ph_q;
  logic [3:0]  mode_q;
  logic [15:0] pc_q;
  logic [15:0] ptr_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [7:0]  lo_q;

  cpu8am_pkg::ea_result_t pending_ea[$];
  cpu8am_pkg::ea_result_t want;
  int          mismatches = 0;
  int          snd_idle = 8;
  int          rcv_idle = 55;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task check_field(input string name, input logic [15:0] got, input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
  endtask

  // Number of read-data transfers a mode takes from start to done.
  function automatic int operand_reads(input logic [3:0] m);
    case (m) inside
      cpu8am_pkg::MODE_ZP0, cpu8am_pkg::MODE_ZPX,
      cpu8am_pkg::MODE_ZPY, cpu8am_pkg::MODE_REL: return 1;
      cpu8am_pkg::MODE_ABS, cpu8am_pkg::MODE_ABX,
      cpu8am_pkg::MODE_ABY:                       return 2;
      cpu8am_pkg::MODE_IZX, cpu8am_pkg::MODE_IZY: return 3;
      cpu8am_pkg::MODE_IND:                       return 4;
      default:                                    return 0;
    endcase
  endfunction

  // Start transfers always answer with one result.
  task predict_start(input logic [3:0] m, input logic [15:0] p,
                     input logic [7:0] xv, input logic [7:0] yv);
    cpu8am_pkg::ea_result_t r;
    mode_q = m;
    pc_q = p;
    x_q = xv;
    y_q = yv;
    ptr_q = '0;
    lo_q = '0;
    ph_q = cpu8am_pkg::PH_IDLE;
    if (m == cpu8am_pkg::MODE_IMM) begin
      r = {cpu8am_pkg::KIND_DONE, p, 8'h00, p + 16'd1, 1'b0};
    end else if (m >= cpu8am_pkg::MODE_ZP0 && m <= cpu8am_pkg::MODE_IZY) begin
      r = {cpu8am_pkg::KIND_READ, p, 24'h0, 1'b0};
      ph_q = cpu8am_pkg::PH_OPER1;
    end else begin
      // implied and unused codes finish at once
      r = {cpu8am_pkg::KIND_DONE, 16'h0000, 8'h00, p, 1'b0};
    end
    pending_ea.push_back(r);
  endtask

  // Data transfers walk the operand and pointer fetches.
  task predict_data(input logic [7:0] b);
    logic [15:0] pc1, pc2, base, ea;
    logic [7:0]  idx;
    cpu8am_pkg::ea_result_t r;
    logic        hit;
    cpu8am_pkg::phase_t cur;
    pc1 = pc_q + 16'd1;
    pc2 = pc_q + 16'd2;
    base = {b, lo_q};
    hit = 1'b1;
    cur = ph_q;
    ph_q = cpu8am_pkg::PH_IDLE;
    r = '0;
    case (cur)
      cpu8am_pkg::PH_OPER1: begin
        case (mode_q) inside
          cpu8am_pkg::MODE_ZP0: r = {cpu8am_pkg::KIND_DONE, 8'h00, b, 8'h00, pc1, 1'b0};
          cpu8am_pkg::MODE_ZPX: begin
            idx = b + x_q;
            r = {cpu8am_pkg::KIND_DONE, 8'h00, idx, 8'h00, pc1, 1'b0};
          end
          cpu8am_pkg::MODE_ZPY: begin
            idx = b + y_q;
            r = {cpu8am_pkg::KIND_DONE, 8'h00, idx, 8'h00, pc1, 1'b0};
          end
          cpu8am_pkg::MODE_REL: begin
            ea = pc1 + {{8{b[7]}}, b};
            r = {cpu8am_pkg::KIND_DONE, ea, b, pc1, 1'b0};
          end
          cpu8am_pkg::MODE_ABS, cpu8am_pkg::MODE_ABX,
          cpu8am_pkg::MODE_ABY, cpu8am_pkg::MODE_IND: begin
            lo_q = b;
            r = {cpu8am_pkg::KIND_READ, pc1, 24'h0, 1'b0};
            ph_q = cpu8am_pkg::PH_OPER2;
          end
          cpu8am_pkg::MODE_IZX, cpu8am_pkg::MODE_IZY: begin
            idx = (mode_q == cpu8am_pkg::MODE_IZX) ? b + x_q : b;
            ptr_q = {8'h00, idx};
            r = {cpu8am_pkg::KIND_READ, ptr_q, 24'h0, 1'b0};
            ph_q = cpu8am_pkg::PH_PTR_LO;
          end
          default: hit = 1'b0;
        endcase
      end
      cpu8am_pkg::PH_OPER2: begin
        case (mode_q) inside
          cpu8am_pkg::MODE_ABS: r = {cpu8am_pkg::KIND_DONE, base, 8'h00, pc2, 1'b0};
          cpu8am_pkg::MODE_ABX, cpu8am_pkg::MODE_ABY: begin
            idx = (mode_q == cpu8am_pkg::MODE_ABX) ? x_q : y_q;
            ea = base + {8'h00, idx};
            r = {cpu8am_pkg::KIND_DONE, ea, 8'h00, pc2, ea[15:8] != base[15:8]};
          end
          cpu8am_pkg::MODE_IND: begin
            ptr_q = base;
            r = {cpu8am_pkg::KIND_READ, base, 24'h0, 1'b0};
            ph_q = cpu8am_pkg::PH_PTR_LO;
          end
          default: hit = 1'b0;
        endcase
      end
      cpu8am_pkg::PH_PTR_LO: begin
        if (mode_q == cpu8am_pkg::MODE_IND || mode_q == cpu8am_pkg::MODE_IZX ||
            mode_q == cpu8am_pkg::MODE_IZY) begin
          lo_q = b;
          // high pointer byte stays in the same page
          r = {cpu8am_pkg::KIND_READ, ptr_q[15:8], ptr_q[7:0] + 8'd1, 24'h0, 1'b0};
          ph_q = cpu8am_pkg::PH_PTR_HI;
        end else begin
          hit = 1'b0;
        end
      end
      cpu8am_pkg::PH_PTR_HI: begin
        case (mode_q)
          cpu8am_pkg::MODE_IND: r = {cpu8am_pkg::KIND_DONE, base, 8'h00, pc2, 1'b0};
          cpu8am_pkg::MODE_IZX: r = {cpu8am_pkg::KIND_DONE, base, 8'h00, pc1, 1'b0};
          cpu8am_pkg::MODE_IZY: begin
            ea = base + {8'h00, y_q};
            r = {cpu8am_pkg::KIND_DONE, ea, 8'h00, pc1, ea[15:8] != base[15:8]};
          end
          default: hit = 1'b0;
        endcase
      end
      default: hit = 1'b0;
    endcase
    if (hit) pending_ea.push_back(r);
  endtask

  // Checks results and tracks accepted transfers, both at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      ph_q = cpu8am_pkg::PH_IDLE;
      mode_q = '0;
      pc_q = '0;
      ptr_q = '0;
      x_q = '0;
      y_q = '0;
      lo_q = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_ea.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_ea.pop_front();
          check_field("kind", 16'(out_kind), 16'(want.kind));
          check_field("address", out_address, want.address);
          check_field("rel_offset", 16'($unsigned(out_rel_offset)), 16'(want.rel_offset));
          check_field("next_pc", out_next_pc, want.next_pc);
          check_field("page_cross", 16'(out_page_cross), 16'(want.page_cross));
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type == cpu8am_pkg::REQ_START)
          predict_start(in_mode, in_pc, in_x_index, in_y_index);
        else
          predict_data(in_read_data);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  task send_item(input logic rt, input logic [3:0] m, input logic [15:0] p,
                 input logic [7:0] xv, input logic [7:0] yv, input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= rt;
    in_mode      <= m;
    in_pc        <= p;
    in_x_index   <= xv;
    in_y_index   <= yv;
    in_read_data <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Start transfer, then the operand bytes low first; skip drops trailing ones.
  task automatic run_seq(input logic [3:0] m, input logic [15:0] p, input logic [7:0] xv,
                         input logic [7:0] yv, input logic [31:0] ops, input int skip);
    int n;
    n = operand_reads(m) - skip;
    send_item(cpu8am_pkg::REQ_START, m, p, xv, yv, 8'($urandom));
    for (int i = 0; i < n; i++)
      send_item(cpu8am_pkg::REQ_DATA, 4'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), ops[8*i +: 8]);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(7))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = 8'h80;
      3: v = 8'h7F;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(7))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v[7:0] = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  task test_mode_corners();
    run_seq(cpu8am_pkg::MODE_IMP, 16'hFFFF, 8'hFF, 8'hFF, 32'h0, 0);
    run_seq(cpu8am_pkg::MODE_IMM, 16'hFFFF, 8'h00, 8'h00, 32'h0, 0);
    run_seq(4'd15, 16'h1234, 8'h55, 8'hAA, 32'h0, 0);
    // zero-page index wraps inside page zero
    run_seq(cpu8am_pkg::MODE_ZPX, 16'h8000, 8'h20, 8'h00, 32'h0000_00F0, 0);
    // backward branch from the bottom of memory
    run_seq(cpu8am_pkg::MODE_REL, 16'h0000, 8'h00, 8'h00, 32'h0000_0080, 0);
    run_seq(cpu8am_pkg::MODE_ABX, 16'h0200, 8'hFF, 8'h00, 32'h0000_12F0, 0);
    run_seq(cpu8am_pkg::MODE_ABY, 16'h0300, 8'h00, 8'h01, 32'h0000_FFFF, 0);
    // pointer at a page end takes its high byte from the page start
    run_seq(cpu8am_pkg::MODE_IND, 16'hFFFE, 8'h00, 8'h00, 32'h5634_02FF, 0);
    run_seq(cpu8am_pkg::MODE_IZX, 16'h0500, 8'h7F, 8'h00, 32'h0012_3480, 0);
    run_seq(cpu8am_pkg::MODE_IZY, 16'hFFFE, 8'h00, 8'hFF, 32'h0020_FFFF, 0);
  endtask

  task test_restart_and_stray();
    send_item(cpu8am_pkg::REQ_DATA, 4'd0, 16'h0000, 8'h00, 8'h00, 8'hA5);
    run_seq(cpu8am_pkg::MODE_IND, 16'h1000, 8'h00, 8'h00, 32'h0000_0034, 3);
    run_seq(cpu8am_pkg::MODE_ZPY, 16'h2000, 8'h00, 8'h81, 32'h0000_00FF, 0);
    send_item(cpu8am_pkg::REQ_DATA, 4'hF, 16'hFFFF, 8'hFF, 8'hFF, 8'h5A);
  endtask

  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    int sent, full, skip;
    logic [3:0] m;
    snd_idle = s_idle;
    rcv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) m = 4'($urandom_range(15));
      else m = 4'($urandom_range(cpu8am_pkg::MODE_IZY, cpu8am_pkg::MODE_ZP0));
      full = operand_reads(m);
      skip = 0;
      // broken sequence: the next start lands while the unit is busy
      if (full > 0 && $urandom_range(99) < 8) skip = int'($urandom_range(full, 1));
      run_seq(m, pick_word(), pick_byte(), pick_byte(),
              {pick_byte(), pick_byte(), pick_byte(), pick_byte()}, skip);
      sent += 1 + full - skip;
      if (skip == 0 && $urandom_range(99) < 4)
        send_item(cpu8am_pkg::REQ_DATA, 4'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom), pick_byte());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = cpu8am_pkg::REQ_START;
    in_mode      = '0;
    in_pc        = '0;
    in_x_index   = '0;
    in_y_index   = '0;
    in_read_data = '0;
    out_ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mode_corners();
    test_restart_and_stray();
    test_random_traffic(650, 8, 55);
    test_random_traffic(650, 55, 8);
    test_random_traffic(650, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ea.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
